// File: hdl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hdl/pafl_pkg.sv
// Package of the page and block free-list allocator: types, codes and defaults.
`default_nettype none
package pafl_pkg;

	localparam int ADDR_W     = 32;
	localparam int PAGE_CNT_W = 11;
	localparam int BSIZE_W    = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int PAGE_BYTES_DEF  = 4096;
	localparam int MAX_PAGES_DEF   = 1024;
	localparam int BLOCK_SLOTS_DEF = 1024;

	localparam logic [ADDR_W-1:0]     HEAP_BASE_RST  = '0;
	localparam logic [PAGE_CNT_W-1:0] PAGE_TOTAL_RST = PAGE_CNT_W'(1024);
	localparam logic [BSIZE_W-1:0]    BLOCK_SIZE_RST = BSIZE_W'(64);

	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_TOTAL = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = CFG_IDX_W'(2);

	typedef enum logic [1:0] {
		KIND_ALLOC_PAGE  = 2'd0,
		KIND_FREE_PAGE   = 2'd1,
		KIND_ALLOC_BLOCK = 2'd2,
		KIND_FREE_BLOCK  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OOM  = 2'd1,
		ST_FULL = 2'd2
	} status_t;

endpackage
`default_nettype wire

// File: hdl/pafl_if.sv
// Request and response channel interfaces of the allocator.
`default_nettype none
interface pafl_req_if;
	import pafl_pkg::*;
	logic                valid;
	logic                ready;
	kind_t               kind;
	logic [ADDR_W-1:0]   address;
	modport source (output valid, output kind, output address, input ready);
	modport sink   (input valid, input kind, input address, output ready);
endinterface

interface pafl_rsp_if;
	import pafl_pkg::*;
	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   result_address;
	status_t             status;
	modport source (output valid, output result_address, output status, input ready);
	modport sink   (input valid, input result_address, input status, output ready);
endinterface
`default_nettype wire

// File: hdl/pafl_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module pafl_ram #(
	parameter int W = 32,
	parameter int D = 1024,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: hdl/pafl_div.sv
// Bit-serial restoring divider: page size divided by the block size.
`default_nettype none
module pafl_div #(
	parameter int PAGE_BYTES = 4096,
	localparam int EW = $clog2(PAGE_BYTES + 1),
	localparam int CW = $clog2(PAGE_BYTES / 4 + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [EW-1:0] divisor,
	output logic               done,
	output logic      [CW-1:0] quotient
);
	localparam int NW = $clog2(EW + 1);

	logic [EW-1:0] rem_q;
	logic [EW-1:0] dvd_q;
	logic [EW-1:0] quo_q;
	logic [EW-1:0] dsr_q;
	logic [NW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [EW:0]   trial;
	logic          fits;

	assign trial    = {rem_q, dvd_q[EW-1]};
	assign fits     = trial >= {1'b0, dsr_q};
	assign done     = done_q;
	assign quotient = quo_q[CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvd_q  <= '0;
			quo_q  <= '0;
			dsr_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= NW'(EW);
				rem_q  <= '0;
				dvd_q  <= EW'(PAGE_BYTES);
				quo_q  <= '0;
				dsr_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= fits ? EW'(trial - {1'b0, dsr_q}) : trial[EW-1:0];
				dvd_q <= {dvd_q[EW-2:0], 1'b0};
				quo_q <= {quo_q[EW-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: hdl/page_and_block_free_list_allocator.sv
// Top level of the LIFO page and block free-list allocator.
//
//  channel  dir  payload                   role
//  req      in   kind, address             allocate or free request
//  rsp      out  result_address, status    one result per request
//  cfg      in   cfg_index, cfg_wdata      heap_base, page_total, block_size
//
// One request at a time. A free goes straight to the done state; a pop from either stack
// does one RAM read, and a fresh page or the next carved block one multiply, then the add.
// Starting a new carve page adds the serial divider before the block multiply.
// Both stacks live in RAM and need no clearing pass; reset acts only on registers.
// A new request is taken while the previous result waits in the output register.
`default_nettype none
module page_and_block_free_list_allocator #(
	parameter int PAGE_BYTES  = pafl_pkg::PAGE_BYTES_DEF,
	parameter int MAX_PAGES   = pafl_pkg::MAX_PAGES_DEF,
	parameter int BLOCK_SLOTS = pafl_pkg::BLOCK_SLOTS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [pafl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pafl_pkg::CFG_DATA_W-1:0] cfg_wdata,
	pafl_req_if.sink                            req,
	pafl_rsp_if.source                          rsp
);
	import pafl_pkg::*;

	localparam int EW  = $clog2(PAGE_BYTES + 1);
	localparam int CW  = $clog2(PAGE_BYTES / 4 + 1);
	localparam int MW  = (CW > PAGE_CNT_W) ? CW : PAGE_CNT_W;
	localparam int PW  = (MW + EW > ADDR_W) ? MW + EW : ADDR_W;
	localparam int WW  = (BSIZE_W > EW) ? BSIZE_W : EW;
	localparam int PTW = $clog2(MAX_PAGES + 1);
	localparam int BTW = $clog2(BLOCK_SLOTS + 1);
	localparam int PAW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int BAW = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;

	typedef enum logic [2:0] {
		S_IDLE, S_PRD, S_BRD, S_PMUL, S_BMUL, S_DIV, S_DONE
	} state_t;

	state_t                state_q;
	logic [ADDR_W-1:0]     heap_base_q;
	logic [BSIZE_W-1:0]    block_size_q;
	logic [PAGE_CNT_W-1:0] fresh_q;
	logic [PTW-1:0]        page_top_q;
	logic [BTW-1:0]        block_top_q;
	logic [ADDR_W-1:0]     carve_page_q;
	logic [CW-1:0]         carve_left_q;
	logic                  for_carve_q;
	logic [ADDR_W-1:0]     prod_s1;
	logic [ADDR_W-1:0]     res_q;
	status_t               st_q;
	logic                  rsp_valid_q;
	logic [ADDR_W-1:0]     rsp_addr_q;
	status_t               rsp_st_q;

	logic                  accept;
	logic                  page_full;
	logic                  block_full;
	logic                  page_push;
	logic                  block_push;
	logic                  page_pop;
	logic                  block_pop;
	logic                  need_page;
	logic [PTW-1:0]        page_top_dec;
	logic [BTW-1:0]        block_top_dec;
	logic [ADDR_W-1:0]     page_rdata;
	logic [ADDR_W-1:0]     block_rdata;
	logic [WW-1:0]         eff_w;
	logic [EW-1:0]         eff;
	logic [MW-1:0]         mul_a;
	logic [EW-1:0]         mul_b;
	logic [PW-1:0]         mul_full;
	logic                  div_start;
	logic                  div_done;
	logic [CW-1:0]         div_q;
	logic [ADDR_W-1:0]     fresh_addr;

	assign req.ready          = (state_q == S_IDLE);
	assign rsp.valid          = rsp_valid_q;
	assign rsp.result_address = rsp_addr_q;
	assign rsp.status         = rsp_st_q;

	assign accept        = req.valid && req.ready;
	assign page_full     = (page_top_q == PTW'(MAX_PAGES));
	assign block_full    = (block_top_q == BTW'(BLOCK_SLOTS));
	assign page_top_dec  = page_top_q - 1'b1;
	assign block_top_dec = block_top_q - 1'b1;
	assign need_page     = (req.kind == KIND_ALLOC_PAGE) ||
	                       ((req.kind == KIND_ALLOC_BLOCK) && (block_top_q == '0) &&
	                        (carve_left_q == '0));
	assign page_push     = accept && (req.kind == KIND_FREE_PAGE) && !page_full;
	assign block_push    = accept && (req.kind == KIND_FREE_BLOCK) && !block_full;
	assign page_pop      = accept && need_page && (page_top_q != '0);
	assign block_pop     = accept && (req.kind == KIND_ALLOC_BLOCK) && (block_top_q != '0);
	assign div_start     = for_carve_q && ((state_q == S_PRD) || (state_q == S_PMUL));
	assign fresh_addr    = heap_base_q + prod_s1;

	always_comb begin
		if (WW'(block_size_q) < WW'(4)) begin
			eff_w = WW'(4);
		end else if (WW'(block_size_q) > WW'(PAGE_BYTES)) begin
			eff_w = WW'(PAGE_BYTES);
		end else begin
			eff_w = WW'(block_size_q);
		end
	end
	assign eff = eff_w[EW-1:0];

	always_comb begin
		if (state_q == S_DIV) begin
			mul_a = MW'(div_q - 1'b1);
			mul_b = eff;
		end else if ((req.kind == KIND_ALLOC_BLOCK) && (block_top_q == '0) &&
		             (carve_left_q != '0)) begin
			mul_a = MW'(carve_left_q - 1'b1);
			mul_b = eff;
		end else begin
			mul_a = MW'(fresh_q - 1'b1);
			mul_b = EW'(PAGE_BYTES);
		end
		mul_full = mul_a * mul_b;
	end

	pafl_ram #(.W(ADDR_W), .D(MAX_PAGES)) u_page_ram (
		.clk   (clk),
		.we    (page_push),
		.waddr (page_top_q[PAW-1:0]),
		.wdata (req.address),
		.re    (page_pop),
		.raddr (page_top_dec[PAW-1:0]),
		.rdata (page_rdata)
	);

	pafl_ram #(.W(ADDR_W), .D(BLOCK_SLOTS)) u_block_ram (
		.clk   (clk),
		.we    (block_push),
		.waddr (block_top_q[BAW-1:0]),
		.wdata (req.address),
		.re    (block_pop),
		.raddr (block_top_dec[BAW-1:0]),
		.rdata (block_rdata)
	);

	pafl_div #(.PAGE_BYTES(PAGE_BYTES)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (eff),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			heap_base_q  <= HEAP_BASE_RST;
			block_size_q <= BLOCK_SIZE_RST;
			fresh_q      <= PAGE_TOTAL_RST;
			page_top_q   <= '0;
			block_top_q  <= '0;
			carve_page_q <= '0;
			carve_left_q <= '0;
			for_carve_q  <= 1'b0;
			prod_s1      <= '0;
			res_q        <= '0;
			st_q         <= ST_OK;
			rsp_valid_q  <= 1'b0;
			rsp_addr_q   <= '0;
			rsp_st_q     <= ST_OK;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_HEAP_BASE: begin
						heap_base_q <= cfg_wdata[ADDR_W-1:0];
					end
					CFG_PAGE_TOTAL: begin
						fresh_q <= cfg_wdata[PAGE_CNT_W-1:0];
					end
					CFG_BLOCK_SIZE: begin
						block_size_q <= cfg_wdata[BSIZE_W-1:0];
					end
					default: begin
					end
				endcase
			end

			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_q       <= '0;
						st_q        <= ST_OK;
						for_carve_q <= (req.kind == KIND_ALLOC_BLOCK);
						prod_s1     <= mul_full[ADDR_W-1:0];
						state_q     <= S_DONE;
						case (req.kind)
							KIND_FREE_PAGE: begin
								if (page_full) begin
									st_q <= ST_FULL;
								end else begin
									page_top_q <= page_top_q + 1'b1;
								end
							end
							KIND_FREE_BLOCK: begin
								if (block_full) begin
									st_q <= ST_FULL;
								end else begin
									block_top_q <= block_top_q + 1'b1;
								end
							end
							default: begin
								if (block_pop) begin
									block_top_q <= block_top_dec;
									state_q     <= S_BRD;
								end else if (!need_page) begin
									carve_left_q <= carve_left_q - 1'b1;
									state_q      <= S_BMUL;
								end else if (page_top_q != '0) begin
									page_top_q <= page_top_dec;
									state_q    <= S_PRD;
								end else if (fresh_q != '0) begin
									fresh_q <= fresh_q - 1'b1;
									state_q <= S_PMUL;
								end else begin
									st_q <= ST_OOM;
								end
							end
						endcase
					end
				end
				S_PRD: begin
					if (for_carve_q) begin
						carve_page_q <= page_rdata;
						state_q      <= S_DIV;
					end else begin
						res_q   <= page_rdata;
						state_q <= S_DONE;
					end
				end
				S_PMUL: begin
					if (for_carve_q) begin
						carve_page_q <= fresh_addr;
						state_q      <= S_DIV;
					end else begin
						res_q   <= fresh_addr;
						state_q <= S_DONE;
					end
				end
				S_BRD: begin
					res_q   <= block_rdata;
					state_q <= S_DONE;
				end
				S_DIV: begin
					if (div_done) begin
						carve_left_q <= div_q - 1'b1;
						prod_s1      <= mul_full[ADDR_W-1:0];
						state_q      <= S_BMUL;
					end
				end
				S_BMUL: begin
					res_q   <= carve_page_q + prod_s1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_addr_q  <= res_q;
						rsp_st_q    <= st_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// File: hdl/pafl_checker.sv
// Port-level checker for the allocator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module pafl_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        req_valid,
	input wire logic                        req_ready,
	input wire logic                        rsp_valid,
	input wire logic                        rsp_ready,
	input wire logic [pafl_pkg::ADDR_W-1:0] rsp_result_address,
	input wire logic [1:0]                  rsp_status
);
	import pafl_pkg::*;

	logic rsp_fail;
	assign rsp_fail = rsp_valid && (rsp_status != ST_OK);

	`ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`ASSERT_NXT(a_one_at_a_time, clk, arst_n, req_valid && req_ready, !req_ready)
	`ASSERT_IMP(a_fail_zero_addr, clk, arst_n, rsp_fail, rsp_result_address == '0)
endmodule

bind page_and_block_free_list_allocator pafl_checker u_pafl_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_result_address (rsp.result_address),
	.rsp_status         (rsp.status)
);
`default_nettype wire

// File: dv/page_and_block_free_list_allocator_test.sv
// Self-checking testbench of the LIFO page and block free-list allocator.
`timescale 1ns / 1ps
module page_and_block_free_list_allocator_test;
	import pafl_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE = 40;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		status_t           status;
	} alloc_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	pafl_req_if req_bus ();
	pafl_rsp_if rsp_bus ();

	page_and_block_free_list_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_bus),
		.rsp       (rsp_bus)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// allocator mirror
	logic [ADDR_W-1:0]     heap_base_cfg;
	logic [BSIZE_W-1:0]    block_size_cfg;
	logic [PAGE_CNT_W-1:0] fresh_left;
	logic [ADDR_W-1:0]     page_lifo [MAX_PAGES_DEF];
	logic [PAGE_CNT_W-1:0] page_depth;
	logic [ADDR_W-1:0]     block_lifo [BLOCK_SLOTS_DEF];
	logic [PAGE_CNT_W-1:0] block_depth;
	logic [ADDR_W-1:0]     carve_base;
	logic [BSIZE_W-1:0]    carve_count;

	alloc_result_t pending_results [$];

	int items_sent, results_checked, oom_seen, full_seen, cfg_writes, fail_count;
	int send_idle_pct, stall_pct;
	int hold_len, hold_req, hold_ack, hold_left;
	int idle_cycles;

	function automatic int unsigned block_bytes();
		if (block_size_cfg < 4)
			return 4;
		if (block_size_cfg > PAGE_BYTES_DEF)
			return PAGE_BYTES_DEF;
		return block_size_cfg;
	endfunction

	function automatic bit take_page(output logic [ADDR_W-1:0] pg);
		pg = '0;
		if (page_depth != 0) begin
			page_depth--;
			pg = page_lifo[page_depth];
			return 1'b1;
		end
		if (fresh_left != 0) begin
			fresh_left--;
			pg = heap_base_cfg + ADDR_W'(fresh_left) * ADDR_W'(PAGE_BYTES_DEF);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic alloc_result_t predict_result(kind_t k, logic [ADDR_W-1:0] a);
		alloc_result_t r;
		logic [ADDR_W-1:0] pg;
		bit ok;
		r.addr = '0;
		r.status = ST_OK;
		case (k)
			KIND_ALLOC_PAGE: begin
				if (take_page(pg))
					r.addr = pg;
				else
					r.status = ST_OOM;
			end
			KIND_FREE_PAGE: begin
				if (page_depth >= MAX_PAGES_DEF) begin
					r.status = ST_FULL;
				end else begin
					page_lifo[page_depth] = a;
					page_depth++;
				end
			end
			KIND_ALLOC_BLOCK: begin
				if (block_depth != 0) begin
					block_depth--;
					r.addr = block_lifo[block_depth];
				end else begin
					ok = 1'b1;
					if (carve_count == 0) begin
						ok = take_page(pg);
						if (ok) begin
							carve_base = pg;
							carve_count = BSIZE_W'(PAGE_BYTES_DEF / block_bytes());
						end
					end
					if (ok) begin
						carve_count--;
						r.addr = carve_base + ADDR_W'(carve_count) * ADDR_W'(block_bytes());
					end else begin
						r.status = ST_OOM;
					end
				end
			end
			default: begin
				if (block_depth >= BLOCK_SLOTS_DEF) begin
					r.status = ST_FULL;
				end else begin
					block_lifo[block_depth] = a;
					block_depth++;
				end
			end
		endcase
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] rand_address();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic set_idle(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
	endtask

	task automatic send_item(input kind_t k, input logic [ADDR_W-1:0] a);
		while ($urandom_range(99) < send_idle_pct) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.kind <= k;
		req_bus.address <= a;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		pending_results.push_back(predict_result(k, a));
		items_sent++;
	endtask

	// lower valid at once, then wait for every outstanding result plus the tail latency
	task automatic wait_idle();
		req_bus.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_writes++;
		case (idx)
			CFG_HEAP_BASE: heap_base_cfg = data;
			CFG_PAGE_TOTAL: fresh_left = data[PAGE_CNT_W-1:0];
			CFG_BLOCK_SIZE: block_size_cfg = data[BSIZE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic test_page_lifo();
		set_idle(0, 0);
		send_item(KIND_ALLOC_PAGE, '1);
		send_item(KIND_FREE_PAGE, '0);
		send_item(KIND_FREE_PAGE, '1);
		send_item(KIND_ALLOC_PAGE, '0);
		send_item(KIND_ALLOC_PAGE, 32'h5A5A_A5A5);
	endtask

	task automatic test_out_of_memory();
		set_idle(0, 0);
		write_reg(CFG_PAGE_TOTAL, '0);
		send_item(KIND_ALLOC_PAGE, '0);
		send_item(KIND_ALLOC_BLOCK, '1);
		write_reg(CFG_BLOCK_SIZE, 32'd4096);
		write_reg(CFG_PAGE_TOTAL, 32'd1);
		send_item(KIND_ALLOC_BLOCK, '0);
		send_item(KIND_ALLOC_BLOCK, '0);
		send_item(KIND_ALLOC_PAGE, '0);
	endtask

	task automatic test_block_carving();
		set_idle(0, 0);
		write_reg(CFG_PAGE_TOTAL, 32'd1024);
		write_reg(CFG_BLOCK_SIZE, 32'd64);
		send_item(KIND_ALLOC_BLOCK, '0);
		send_item(KIND_FREE_BLOCK, 32'hA5A5_A5A5);
		send_item(KIND_ALLOC_BLOCK, '0);
		// resize in the middle of a page: remaining count kept, new stride used
		write_reg(CFG_BLOCK_SIZE, 32'd4);
		send_item(KIND_ALLOC_BLOCK, '0);
		write_reg(CFG_BLOCK_SIZE, '0);
		send_item(KIND_ALLOC_BLOCK, '0);
		write_reg(CFG_BLOCK_SIZE, 32'h1FFF);
		send_item(KIND_ALLOC_BLOCK, '0);
		write_reg(CFG_BLOCK_SIZE, 32'd3);
		write_reg(CFG_UNUSED, '1);
		send_item(KIND_ALLOC_BLOCK, '1);
	endtask

	task automatic test_address_wrap();
		set_idle(0, 0);
		write_reg(CFG_HEAP_BASE, 32'hFFFF_F000);
		send_item(KIND_ALLOC_PAGE, '0);
		write_reg(CFG_HEAP_BASE, '1);
		write_reg(CFG_PAGE_TOTAL, 32'd1024);
		send_item(KIND_ALLOC_PAGE, '0);
		write_reg(CFG_HEAP_BASE, '0);
	endtask

	task automatic test_stack_full();
		set_idle(0, 0);
		write_reg(CFG_BLOCK_SIZE, 32'd64);
		for (int i = 0; i < MAX_PAGES_DEF + 2; i++)
			send_item(KIND_FREE_PAGE, rand_address());
		for (int i = 0; i < 64; i++)
			send_item(KIND_ALLOC_PAGE, $urandom);
		for (int i = 0; i < 64; i++)
			send_item(KIND_FREE_BLOCK, rand_address());
		for (int i = 0; i < 65; i++)
			send_item(KIND_ALLOC_BLOCK, $urandom);
	endtask

	task automatic test_random_mix();
		kind_t k;
		int alloc_pct;
		logic [CFG_DATA_W-1:0] hb, pt, bs;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: set_idle(0, 0);
				1: set_idle(74, 0);
				2: set_idle(0, 74);
				default: set_idle(34, 34);
			endcase
			for (int sub = 0; sub < 2; sub++) begin
				case ($urandom_range(3))
					0: hb = '0;
					1: hb = '1;
					2: hb = $urandom & 32'hFFFF_F000;
					default: hb = $urandom;
				endcase
				case ($urandom_range(4))
					0: pt = '0;
					1: pt = 32'd1024;
					2: pt = $urandom_range(16);
					default: pt = $urandom_range(1024);
				endcase
				case ($urandom_range(5))
					0: bs = 32'd4;
					1: bs = 32'd4096;
					2: bs = $urandom_range(3);
					3: bs = $urandom_range(8191, 4097);
					4: bs = 32'd1 << $urandom_range(12, 2);
					default: bs = $urandom_range(4096, 4);
				endcase
				write_reg(CFG_HEAP_BASE, hb);
				write_reg(CFG_PAGE_TOTAL, pt);
				write_reg(CFG_BLOCK_SIZE, bs);
				alloc_pct = $urandom_range(75, 40);
				for (int i = 0; i < 80; i++) begin
					if ($urandom_range(99) < alloc_pct) begin
						k = $urandom_range(1) ? KIND_ALLOC_PAGE : KIND_ALLOC_BLOCK;
						send_item(k, $urandom);
					end else begin
						k = $urandom_range(1) ? KIND_FREE_PAGE : KIND_FREE_BLOCK;
						send_item(k, rand_address());
					end
				end
			end
		end
	endtask

	task automatic test_backpressure();
		set_idle(0, 0);
		hold_len = HOLD_CYCLES;
		hold_req++;
		for (int i = 0; i < 16; i++)
			send_item(kind_t'($urandom_range(3)), rand_address());
		wait_idle();
		set_idle(34, 34);
		for (int i = 0; i < 8; i++)
			send_item(kind_t'($urandom_range(3)), rand_address());
	endtask

	// result checker and ready driver
	initial begin
		alloc_result_t want;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
				if (pending_results.size() == 0) begin
					$error("result beat with nothing outstanding: result_address %h status %0d",
						rsp_bus.result_address, rsp_bus.status);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (rsp_bus.result_address !== want.addr) begin
						$error("result_address: expected %h, actual %h",
							want.addr, rsp_bus.result_address);
						fail_count++;
					end
					if (rsp_bus.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
						fail_count++;
					end
					if (want.status == ST_OOM)
						oom_seen++;
					if (want.status == ST_FULL)
						full_seen++;
					results_checked++;
				end
			end
			if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				hold_left = hold_len;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		heap_base_cfg = HEAP_BASE_RST;
		block_size_cfg = BLOCK_SIZE_RST;
		fresh_left = PAGE_TOTAL_RST;
		page_depth = '0;
		block_depth = '0;
		carve_base = '0;
		carve_count = '0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_HEAP_BASE;
		cfg_wdata <= '0;
		req_bus.valid <= 1'b0;
		req_bus.kind <= KIND_ALLOC_PAGE;
		req_bus.address <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_page_lifo();
		test_out_of_memory();
		test_block_carving();
		test_address_wrap();
		test_stack_full();
		test_random_mix();
		test_backpressure();
		wait_idle();

		$display("checked %0d results of %0d requests: %0d out of memory, %0d free rejected",
			results_checked, items_sent, oom_seen, full_seen);
		$display("%0d register writes, four idle mixes, one long result stall, page stack overfilled",
			cfg_writes);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
